[design/fqa_pkg.sv]
package fqa_pkg;

   typedef enum logic [2:0] {
      CMD_ENQUEUE = 3'd0,
      CMD_DEQUEUE = 3'd1,
      CMD_CLEAR   = 3'd2,
      CMD_INVERT  = 3'd3,
      CMD_REMOVE  = 3'd4,
      CMD_COUNT   = 3'd5,
      CMD_QUERY   = 3'd6,
      CMD_SPARE   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REJECTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   localparam int CMD_BITS    = 3;
   localparam int FIELD_BITS  = 16;
   localparam int COUNT_BITS  = 5;
   localparam int TOTAL_BITS  = 19;
   localparam int STATUS_BITS = 2;

   // Shift command for the cell row
   typedef enum logic [3:0] {
      SH_HOLD  = 4'b0001,
      SH_LOAD  = 4'b0010,
      SH_LEFT  = 4'b0100,
      SH_RIGHT = 4'b1000
   } shift_type;

endpackage

[design/fifo_queue_with_aggregates_top.sv]
// Channel  Direction  tdata fields (low bit up)
// req      in         command[2:0], value_in[18:3], zero fill to 24 bits
// rsp      out        status[1:0], popped_value[17:2], front_value[33:18],
//                     rear_value[49:34], entry_count[54:50], total[73:55],
//                     largest[89:74], smallest[105:90], match_count[110:106],
//                     is_empty[111], zero fill to 128 bits
//
// The queue is a row of DEPTH cells; cell 0 is the front, or the rear when reversed.
// The APPLY state applies the command, then in WALK the row rotates once through its n live
// entries (the count after the command, before it for remove-even) gathering max,
// min, matches and the compacted sum, and the DONE state registers the result.
// A new item is taken only in IDLE, once the last one's result has been registered.
// Reset empties the row. A result waits in the output register while the next item runs;
// that item's result holds until the first one is transferred.
module fifo_queue_with_aggregates_top
   import fqa_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // command, value_in
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // status, popped_value, front_value, rear_value,
                                     // entry_count, total, largest, smallest,
                                     // match_count, is_empty
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [FIELD_BITS-1:0] NO_ENTRY = '1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_APPLY = 4'b0010,
      S_WALK  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   cmd_type                      cmd_ff, cmd_in;
   logic signed [FIELD_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [CNT_W-1:0]             step_ff, step_in;
   logic [CNT_W-1:0]             kept_ff, kept_in;
   logic [CNT_W-1:0]             match_ff, match_in;
   logic [TOTAL_BITS-1:0]        sum_ff, sum_in;
   logic [VALUE_BITS-1:0]        hi_ff, hi_in, lo_ff, lo_in;
   logic                         rev_ff, rev_in;
   status_type                   status_ff, status_in;
   logic signed [FIELD_BITS-1:0] pop_ff, pop_in;
   logic                         out_valid_ff, out_valid_in;
   logic [127:0]                 rsp_data_ff, rsp_data_in;

   shift_type                    shift;
   logic [DEPTH-1:0]             cell_valid, load_sel;
   logic [VALUE_BITS-1:0]        cell_value [DEPTH];
   logic                         load_valid;
   logic [VALUE_BITS-1:0]        load_value;

   logic                         accept, neg, too_wide, keep, empty;
   logic [FIELD_BITS-1:0]        wide_max;
   logic [IDX_W-1:0]             last_idx, push_idx;
   logic [VALUE_BITS-1:0]        front_value, rear_value;

   assign accept   = req_tvalid && req_tready;
   assign neg      = val_ff[FIELD_BITS-1];
   assign wide_max = FIELD_BITS'((33'd1 << VALUE_BITS) - 33'd1);
   assign too_wide = neg || ($unsigned(val_ff) > wide_max);
   assign empty    = (fill_ff == '0);
   assign last_idx = IDX_W'(fill_ff - CNT_W'(1));
   // tail slot for the entry leaving cell 0 once the row has moved left
   assign push_idx = IDX_W'(fill_ff - step_ff + kept_ff - CNT_W'(1));
   // remove-even drops even entries as they leave cell 0
   assign keep     = !(cmd_ff == CMD_REMOVE && !cell_value[0][0]);

   assign front_value = rev_ff ? cell_value[last_idx] : cell_value[0];
   assign rear_value  = rev_ff ? cell_value[0] : cell_value[last_idx];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic                  rv, lv;
         logic [VALUE_BITS-1:0] rval, lval;
         if (g == DEPTH - 1) begin : g_last
            assign rv   = 1'b0;
            assign rval = '0;
         end else begin : g_mid
            assign rv   = cell_valid[g+1];
            assign rval = cell_value[g+1];
         end
         if (g == 0) begin : g_first
            // reversed enqueue enters at cell 0 as the row moves right
            assign lv   = 1'b1;
            assign lval = load_value;
         end else begin : g_rest
            assign lv   = cell_valid[g-1];
            assign lval = cell_value[g-1];
         end
         fqa_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clock            (clock),
            .reset            (reset),
            .shift            (shift),
            .load_here        (load_sel[g]),
            .load_valid       (load_valid),
            .load_value       (load_value),
            .from_right_valid (rv),
            .from_right_value (rval),
            .from_left_valid  (lv),
            .from_left_value  (lval),
            .valid            (cell_valid[g]),
            .value            (cell_value[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      kept_in      = kept_ff;
      match_in     = match_ff;
      sum_in       = sum_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rev_in       = rev_ff;
      status_in    = status_ff;
      pop_in       = pop_ff;
      out_valid_in = out_valid_ff;
      rsp_data_in  = rsp_data_ff;
      shift        = SH_HOLD;
      load_sel     = '0;
      load_valid   = 1'b1;
      load_value   = VALUE_BITS'($unsigned(val_ff));

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_tdata[CMD_BITS-1:0]);
               val_in   = req_tdata[CMD_BITS +: FIELD_BITS];
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            status_in = ST_OK;
            pop_in    = NO_ENTRY;
            case (cmd_ff)
               CMD_ENQUEUE: begin
                  if (too_wide) begin
                     status_in = ST_REJECTED;
                  end else if (fill_ff == CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     if (rev_ff) begin
                        shift = SH_RIGHT;
                     end else begin
                        shift = SH_LOAD;
                        load_sel[IDX_W'(fill_ff)] = 1'b1;
                     end
                     fill_in = fill_ff + 1'b1;
                     sum_in  = sum_ff + TOTAL_BITS'(load_value);
                  end
               end
               CMD_DEQUEUE: begin
                  if (fill_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     if (rev_ff) begin
                        // drop the logical front, held in the last live cell
                        pop_in     = FIELD_BITS'(cell_value[last_idx]);
                        sum_in     = sum_ff - TOTAL_BITS'(cell_value[last_idx]);
                        shift      = SH_LOAD;
                        load_valid = 1'b0;
                        load_sel[last_idx] = 1'b1;
                     end else begin
                        pop_in = FIELD_BITS'(cell_value[0]);
                        sum_in = sum_ff - TOTAL_BITS'(cell_value[0]);
                        shift  = SH_LEFT;
                     end
                     fill_in = fill_ff - 1'b1;
                     if (fill_ff == CNT_W'(1)) rev_in = 1'b0;
                  end
               end
               CMD_CLEAR: begin
                  shift      = SH_LOAD;
                  load_valid = 1'b0;
                  load_sel   = '1;
                  fill_in    = '0;
                  sum_in     = '0;
                  rev_in     = 1'b0;
               end
               CMD_INVERT: begin
                  if (fill_ff > CNT_W'(1)) rev_in = !rev_ff;
               end
               CMD_REMOVE: begin
                  sum_in = '0;
               end
               default: ;
            endcase
            step_in  = '0;
            kept_in  = '0;
            match_in = '0;
            hi_in    = '0;
            lo_in    = '1;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (step_ff == fill_ff) begin
               if (cmd_ff == CMD_REMOVE) fill_in = kept_ff;
               state_in = S_DONE;
            end else begin
               // advance: cell 0 leaves and, if kept, is appended behind the live entries
               shift      = SH_LEFT;
               load_value = cell_value[0];
               step_in    = step_ff + 1'b1;
               if (keep) begin
                  load_sel[push_idx] = 1'b1;
                  kept_in = kept_ff + 1'b1;
                  if (cell_value[0] > hi_ff) hi_in = cell_value[0];
                  if (cell_value[0] < lo_ff) lo_in = cell_value[0];
                  if (cmd_ff == CMD_REMOVE) begin
                     sum_in = sum_ff + TOTAL_BITS'(cell_value[0]);
                  end
                  if (cmd_ff == CMD_COUNT && !neg &&
                      FIELD_BITS'(cell_value[0]) == $unsigned(val_ff)) begin
                     match_in = match_ff + 1'b1;
                  end
               end
            end
         end
         S_DONE: begin
            // hold while the previous result still waits
            if (!out_valid_ff || rsp_tready) begin
               rsp_data_in = {
                  16'd0,
                  empty,
                  COUNT_BITS'(match_ff),
                  empty ? NO_ENTRY : FIELD_BITS'(lo_ff),
                  empty ? NO_ENTRY : FIELD_BITS'(hi_ff),
                  sum_ff,
                  COUNT_BITS'(fill_ff),
                  empty ? NO_ENTRY : FIELD_BITS'(rear_value),
                  empty ? NO_ENTRY : FIELD_BITS'(front_value),
                  pop_ff,
                  STATUS_BITS'(status_ff)
               };
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rev_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rev_ff       <= rev_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      step_ff     <= step_in;
      kept_ff     <= kept_in;
      match_ff    <= match_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      status_ff   <= status_in;
      pop_ff      <= pop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   row_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(cell_valid) == int'(fill_ff)))
      else $error("live cells disagree with fill count");

   fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   drop_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped or changed while waiting");

endmodule

[design/fqa_cell.sv]
// One queue slot. Holds a value and a valid bit, shifts toward either neighbour.
module fqa_cell
   import fqa_pkg::*;
#(
   parameter int VALUE_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  shift_type             shift,
   input  logic                  load_here,
   input  logic                  load_valid,
   input  logic [VALUE_BITS-1:0] load_value,
   input  logic                  from_right_valid,
   input  logic [VALUE_BITS-1:0] from_right_value,
   input  logic                  from_left_valid,
   input  logic [VALUE_BITS-1:0] from_left_value,
   output logic                  valid,
   output logic [VALUE_BITS-1:0] value
);

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (shift)
         SH_LOAD: begin
            if (load_here) begin
               valid_in = load_valid;
               value_in = load_value;
            end
         end
         SH_LEFT: begin
            // a selected cell takes the load instead of its right neighbour
            if (load_here) begin
               valid_in = load_valid;
               value_in = load_value;
            end else begin
               valid_in = from_right_valid;
               value_in = from_right_value;
            end
         end
         SH_RIGHT: begin
            valid_in = from_left_valid;
            value_in = from_left_value;
         end
         SH_HOLD: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

[bench/fifo_queue_with_aggregates_checker.sv]
module fifo_queue_with_aggregates_checker
   import fqa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [23:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   output int           fail_count,
   output int           pending
);
   localparam int DEPTH = 16;
   localparam int VALUE_MAX = 32767;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] popped_value;
      logic [15:0] front_value;
      logic [15:0] rear_value;
      logic [4:0]  entry_count;
      logic [18:0] total;
      logic [15:0] largest;
      logic [15:0] smallest;
      logic [4:0]  match_count;
      logic        is_empty;
   } queue_view;

   // plain ordered list of held values, front first
   int        held[$];
   int        held_sum;
   queue_view views_due[$];

   function automatic queue_view apply_command(cmd_type cmd, logic [15:0] raw);
      queue_view v;
      int        kept[$];
      int        hi, lo;
      v = '0;
      v.status = ST_OK;
      v.popped_value = 16'hFFFF;
      case (cmd)
         CMD_ENQUEUE: begin
            if (raw[15] || int'(raw) > VALUE_MAX) v.status = ST_REJECTED;
            else if (held.size() >= DEPTH) v.status = ST_FULL;
            else begin
               held.push_back(int'(raw));
               held_sum += int'(raw);
            end
         end
         CMD_DEQUEUE: begin
            if (held.size() == 0) v.status = ST_EMPTY;
            else begin
               v.popped_value = 16'(held[0]);
               held_sum -= held[0];
               void'(held.pop_front());
            end
         end
         CMD_CLEAR: begin
            held.delete();
            held_sum = 0;
         end
         CMD_INVERT: held.reverse();
         CMD_REMOVE: begin
            held_sum = 0;
            foreach (held[i]) if (held[i] % 2 == 1) begin
               kept.push_back(held[i]);
               held_sum += held[i];
            end
            held = kept;
         end
         CMD_COUNT: if (!raw[15]) foreach (held[i]) if (held[i] == int'(raw))
            v.match_count++;
         default: ;
      endcase
      v.front_value = 16'hFFFF;
      v.rear_value = 16'hFFFF;
      v.largest = 16'hFFFF;
      v.smallest = 16'hFFFF;
      if (held.size() > 0) begin
         hi = held[0];
         lo = held[0];
         foreach (held[i]) begin
            if (held[i] > hi) hi = held[i];
            if (held[i] < lo) lo = held[i];
         end
         v.front_value = 16'(held[0]);
         v.rear_value = 16'(held[held.size() - 1]);
         v.largest = 16'(hi);
         v.smallest = 16'(lo);
      end
      v.entry_count = 5'(held.size());
      v.total = 19'(held_sum);
      v.is_empty = (held.size() == 0);
      return v;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_view want, got;
      if (reset) begin
         held.delete();
         held_sum = 0;
         views_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            views_due.push_back(apply_command(cmd_type'(req_tdata[2:0]), req_tdata[18:3]));
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tdata[1:0];
            got.popped_value = rsp_tdata[17:2];
            got.front_value  = rsp_tdata[33:18];
            got.rear_value   = rsp_tdata[49:34];
            got.entry_count  = rsp_tdata[54:50];
            got.total        = rsp_tdata[73:55];
            got.largest      = rsp_tdata[89:74];
            got.smallest     = rsp_tdata[105:90];
            got.match_count  = rsp_tdata[110:106];
            got.is_empty     = rsp_tdata[111];
            if (views_due.size() == 0) begin
               $error("result transfer with nothing outstanding");
               fail_count++;
            end else begin
               want = views_due.pop_front();
               compare_field("status", want.status, got.status);
               compare_field("popped_value", want.popped_value, got.popped_value);
               compare_field("front_value", want.front_value, got.front_value);
               compare_field("rear_value", want.rear_value, got.rear_value);
               compare_field("entry_count", want.entry_count, got.entry_count);
               compare_field("total", want.total, got.total);
               compare_field("largest", want.largest, got.largest);
               compare_field("smallest", want.smallest, got.smallest);
               compare_field("match_count", want.match_count, got.match_count);
               compare_field("is_empty", want.is_empty, got.is_empty);
            end
         end
      end
      pending = views_due.size();
   end
endmodule

[bench/fifo_queue_with_aggregates_top_tb.sv]
module fifo_queue_with_aggregates_top_tb;
   import fqa_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   int           fail_count;
   int           pending;
   int           live;

   always #6 clock = ~clock;

   fifo_queue_with_aggregates_top dut (.*);

   fifo_queue_with_aggregates_checker checker_i (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send(cmd_type cmd, logic [15:0] value);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'b0, value, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // track fill level roughly for stimulus shaping
      case (cmd)
         CMD_ENQUEUE: if (!value[15] && live < 16) live++;
         CMD_DEQUEUE: if (live > 0) live--;
         CMD_CLEAR:   live = 0;
         CMD_REMOVE:  live = live / 2;
         default: ;
      endcase
   endtask

   // result side stall pattern
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         g = gap_length();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g - 1) @(posedge clock);
         end else rsp_tready <= 1;
      end
   end

   initial begin
      #10000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int r;
      live = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty edge cases, extremes, every command
      send(CMD_DEQUEUE, 16'h0000);
      send(CMD_INVERT, 16'h0000);
      send(CMD_REMOVE, 16'h0000);
      send(CMD_COUNT, 16'h0000);
      send(CMD_ENQUEUE, 16'h8000);
      send(CMD_ENQUEUE, 16'hFFFF);
      send(CMD_ENQUEUE, 16'h7FFF);
      send(CMD_ENQUEUE, 16'h0000);
      send(CMD_ENQUEUE, 16'h5555);
      send(CMD_ENQUEUE, 16'h2AAA);
      send(CMD_INVERT, 16'h0000);
      send(CMD_COUNT, 16'h7FFF);
      send(CMD_COUNT, 16'hFFFF);
      send(CMD_DEQUEUE, 16'h0000);
      send(CMD_SPARE, 16'h1234);
      send(CMD_QUERY, 16'h0000);
      send(CMD_REMOVE, 16'h0000);
      repeat (14) send(CMD_ENQUEUE, 16'($urandom_range(0, 32767)));
      send(CMD_ENQUEUE, 16'h0001);
      send(CMD_CLEAR, 16'h0000);

      req_tvalid <= 0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      for (int n = 0; n < 950; n++) begin
         r = $urandom_range(0, 99);
         if (n == 500) begin
            req_tvalid <= 0;
            repeat (2) @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if (r < 45 && live < 16)
            send(CMD_ENQUEUE, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                 : 16'($urandom_range(0, ($urandom_range(0, 1) ? 32767 : 7))));
         else if (r < 45)
            send(CMD_ENQUEUE, 16'($urandom_range(0, 32767)));
         else if (r < 68) send(CMD_DEQUEUE, 16'($urandom));
         else if (r < 71) send(CMD_CLEAR, 16'($urandom));
         else if (r < 79) send(CMD_INVERT, 16'($urandom));
         else if (r < 84) send(CMD_REMOVE, 16'($urandom));
         else if (r < 93) send(CMD_COUNT, ($urandom_range(0, 5) == 0) ? 16'($urandom)
                               : 16'($urandom_range(0, 7)));
         else send(($urandom_range(0, 1) ? CMD_QUERY : CMD_SPARE), 16'($urandom));
      end

      req_tvalid <= 0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

[filelist.f]
design/fqa_pkg.sv
design/fqa_cell.sv
design/fifo_queue_with_aggregates_top.sv
bench/fifo_queue_with_aggregates_checker.sv
bench/fifo_queue_with_aggregates_top_tb.sv
